[sv/imufp_pkg.sv]
package imufp_pkg;

    // Frame geometry: every frame is eleven bytes, and a burst is looked at
    // only up to its limit.
    localparam int unsigned FRAME_BYTES = 11;
    localparam int unsigned BURST_BYTES = 33;

    localparam int unsigned FPOS_W = 4;
    localparam int unsigned BPOS_W = 6;

    localparam logic [FPOS_W-1:0] FPOS_HEADER = FPOS_W'(0);
    localparam logic [FPOS_W-1:0] FPOS_TYPE   = FPOS_W'(1);
    localparam logic [FPOS_W-1:0] FPOS_CHECK  = FPOS_W'(FRAME_BYTES - 1);
    localparam logic [BPOS_W-1:0] BPOS_LIMIT  = BPOS_W'(BURST_BYTES);

    localparam logic [7:0] HEADER_RESET = 8'h55;

    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

endpackage

[sv/imufp_if.sv]
interface imufp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_start;

    modport source (output valid, output rx_byte, output burst_start, input ready);
    modport sink   (input valid, input rx_byte, input burst_start, output ready);
endinterface

interface imufp_rec_if;
    logic               valid;
    logic               ready;
    logic [1:0]         record_kind;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;

    modport source (output valid, output record_kind, output value_a, output value_b,
                    output value_c, output value_d, input ready);
    modport sink   (input valid, input record_kind, input value_a, input value_b,
                    input value_c, input value_d, output ready);
endinterface

[sv/imu_frame_parser_top.sv]
// IMU frame parser. Each byte transaction on rx_ch carries one received serial
// byte and a flag that marks the first byte of a receive burst; a burst is cut
// into 11-byte frames from that byte, bytes past the first 33 of a burst are
// ignored, and a trailing partial frame is dropped. A frame whose first byte
// equals the header register (0x55 after reset; the user writes it through
// cfg_we and cfg_wdata only while the block is idle, unenforced) and whose byte
// 10 equals the 8-bit sum of bytes 0 to 9 produces one record transaction on
// rec_ch when its type byte is 0x51 (acceleration), 0x52 (angular rate,
// value_d forced to zero) or 0x53 (angles); all other frames vanish without
// notice. The parser takes one byte per clock cycle: each byte updates a small
// set of frame registers, and a finished record is held in an output register,
// so a record appears on rec_ch in the cycle after its checksum byte is taken.
// Bytes keep flowing while a record waits; only a byte that arrives in the
// checksum slot of the next frame, even one that starts a new burst, is held
// back while the output register is still occupied and not being drained.
module imu_frame_parser_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    imufp_rx_if.sink         rx_ch,
    imufp_rec_if.source      rec_ch
);

    // Configuration register.
    logic [7:0] header_reg;

    // Frame tracking state.
    logic [imufp_pkg::FPOS_W-1:0] fpos_reg, fpos_next;
    logic [imufp_pkg::BPOS_W-1:0] bpos_reg, bpos_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         match_reg, match_next;
    logic [7:0]                   type_reg, type_next;
    logic [63:0]                  payload_reg, payload_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    imufp_pkg::kind_t             kind_reg, kind_next;
    logic [63:0]                  words_reg, words_next;

    logic                         accept;
    logic [imufp_pkg::FPOS_W-1:0] fpos_eff;
    logic [imufp_pkg::BPOS_W-1:0] bpos_eff;
    logic                         frame_ok;
    logic                         kind_known;
    imufp_pkg::kind_t             kind_dec;
    logic                         load;

    // Only a checksum byte makes a record, so the input is held back only when
    // a checksum-slot byte, even a burst start, meets a full, stalled output.
    assign rx_ch.ready = !(out_valid_reg && !rec_ch.ready
                           && (fpos_reg == imufp_pkg::FPOS_CHECK));
    assign accept = rx_ch.valid && rx_ch.ready;

    // A burst start realigns the frame and restarts the burst count.
    assign fpos_eff = rx_ch.burst_start ? imufp_pkg::FPOS_HEADER : fpos_reg;
    assign bpos_eff = rx_ch.burst_start ? '0 : bpos_reg;

    always_comb
    begin
        case (type_reg)
            imufp_pkg::TYPE_ACCEL:
            begin
                kind_dec   = imufp_pkg::KIND_ACCEL;
                kind_known = 1'b1;
            end
            imufp_pkg::TYPE_RATE:
            begin
                kind_dec   = imufp_pkg::KIND_RATE;
                kind_known = 1'b1;
            end
            imufp_pkg::TYPE_ANGLE:
            begin
                kind_dec   = imufp_pkg::KIND_ANGLE;
                kind_known = 1'b1;
            end
            default:
            begin
                kind_dec   = imufp_pkg::KIND_ACCEL;
                kind_known = 1'b0;
            end
        endcase
    end

    assign frame_ok = match_reg && (sum_reg == rx_ch.rx_byte) && kind_known;

    always_comb
    begin
        fpos_next    = fpos_reg;
        bpos_next    = bpos_reg;
        sum_next     = sum_reg;
        match_next   = match_reg;
        type_next    = type_reg;
        payload_next = payload_reg;
        load         = 1'b0;

        // Bytes past the burst limit leave every frame tracking register untouched.
        if (accept && (bpos_eff < imufp_pkg::BPOS_LIMIT))
        begin
            bpos_next = bpos_eff + 1'b1;
            if (fpos_eff == imufp_pkg::FPOS_HEADER)
            begin
                sum_next   = rx_ch.rx_byte;
                match_next = (rx_ch.rx_byte == header_reg);
                fpos_next  = imufp_pkg::FPOS_TYPE;
            end
            else if (fpos_eff == imufp_pkg::FPOS_TYPE)
            begin
                type_next = rx_ch.rx_byte;
                sum_next  = sum_reg + rx_ch.rx_byte;
                fpos_next = fpos_eff + 1'b1;
            end
            else if (fpos_eff != imufp_pkg::FPOS_CHECK)
            begin
                // Payload bytes shift in from the top, so byte 2 ends lowest.
                payload_next = {rx_ch.rx_byte, payload_reg[63:8]};
                sum_next     = sum_reg + rx_ch.rx_byte;
                fpos_next    = fpos_eff + 1'b1;
            end
            else
            begin
                fpos_next = imufp_pkg::FPOS_HEADER;
                load      = frame_ok;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        words_next     = words_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            kind_next      = kind_dec;
            words_next     = payload_reg;
            if (kind_dec == imufp_pkg::KIND_RATE)
            begin
                words_next[63:48] = 16'h0000;
            end
        end
        else if (rec_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= imufp_pkg::HEADER_RESET;
            fpos_reg      <= imufp_pkg::FPOS_HEADER;
            bpos_reg      <= '0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                header_reg <= cfg_wdata;
            end
            fpos_reg      <= fpos_next;
            bpos_reg      <= bpos_next;
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        type_reg    <= type_next;
        payload_reg <= payload_next;
        kind_reg    <= kind_next;
        words_reg   <= words_next;
    end

    assign rec_ch.valid       = out_valid_reg;
    assign rec_ch.record_kind = kind_reg;
    assign rec_ch.value_a     = words_reg[15:0];
    assign rec_ch.value_b     = words_reg[31:16];
    assign rec_ch.value_c     = words_reg[47:32];
    assign rec_ch.value_d     = words_reg[63:48];

    // The frame position never runs past the checksum byte.
    a_fpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        fpos_reg <= imufp_pkg::FPOS_CHECK)
        else $error("frame position out of range");

    // The burst count stops at the burst limit.
    a_bpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        bpos_reg <= imufp_pkg::BPOS_LIMIT)
        else $error("burst position out of range");

    // A new record only follows a checksum byte being taken.
    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (accept && (fpos_eff == imufp_pkg::FPOS_CHECK)))
        else $error("record loaded outside a checksum byte");

    // A pending record is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rec_ch.ready) |=> ($stable(words_reg) && $stable(kind_reg)))
        else $error("pending record overwritten");

    // Angular rate records carry a zero fourth word.
    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == imufp_pkg::KIND_RATE)) |-> (words_reg[63:48] == 16'h0000))
        else $error("rate record with nonzero fourth word");

endmodule
